FILE: hw/rtl/rtt_pkg.sv
package rtt_pkg;

  typedef enum logic [1:0] {
    KIND_ADDED   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_FIRED   = 2'd2,
    KIND_REMOVED = 2'd3
  } kind_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK,
    ST_DRAIN,
    ST_FLUSH
  } state_e;

  // classified command as it travels from front to back
  typedef struct packed {
    logic        is_tick;
    logic [31:0] period;
    logic [31:0] reps;
  } cmd_t;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [31:0] next_due;
    logic [31:0] period;
    logic [31:0] remaining;
  } slot_t;

  localparam int unsigned SlotBits = $bits(slot_t);

endpackage

FILE: hw/rtl/rtt_ram.sv
module rtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/rtt_front.sv
module rtt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          opcode_i,
  input  logic [31:0]   interval_ms_i,
  input  logic [31:0]   repeat_total_i,
  output logic          busy_o,
  output logic          cmd_vld_o,
  output rtt_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import rtt_pkg::*;

  cmd_t       q_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  assign busy_o    = (cnt_q == 2'd2);
  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = q_q[rd_ptr_q];
  assign push      = start_i && !busy_o;
  assign pop       = cmd_pop_i && cmd_vld_o;

  // a zero interval is stored as one
  always_comb begin
    cmd_in.is_tick = (op_e'(opcode_i) == OP_TICK);
    cmd_in.period  = (interval_ms_i == 32'd0) ? 32'd1 : interval_ms_i;
    cmd_in.reps    = repeat_total_i;
  end

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cmd_in;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("pop did not drop the count");

endmodule

FILE: hw/rtl/rtt_back.sv
module rtt_back #(
  parameter int unsigned SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_vld_i,
  input  rtt_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          strobe_o,
  output logic [1:0]    event_kind_o,
  output logic [3:0]    slot_index_o,
  output logic          slot_freed_o,
  output logic          last_o
);
  import rtt_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [31:0]      now_q, now_d;
  logic [SLOTS-1:0] active_q, active_d;
  cmd_t             cmd_q;
  logic             ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0] ev_idx_q, ev_idx_d;

  // held result: the next one decides whether it was the last beat
  logic             pend_vld_q, pend_vld_d;
  kind_e            pend_kind_q, pend_kind_d;
  logic [3:0]       pend_idx_q, pend_idx_d;
  logic             pend_freed_q, pend_freed_d;

  logic             out_stb_q, out_stb_d;
  kind_e            out_kind_q, out_kind_d;
  logic [3:0]       out_idx_q, out_idx_d;
  logic             out_freed_q, out_freed_d;
  logic             out_last_q, out_last_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata, ram_rdata;
  logic [SlotBits-1:0] rdata_raw;

  logic [IDX_W+3:0] idx_wide, ev_idx_wide;
  logic [3:0]       idx4, ev_idx4;
  logic [31:0]      late;
  logic             fire;

  assign idx_wide    = {4'b0000, idx_q};
  assign ev_idx_wide = {4'b0000, ev_idx_q};
  assign idx4        = idx_wide[3:0];
  assign ev_idx4     = ev_idx_wide[3:0];
  assign ram_rdata   = slot_t'(rdata_raw);

  // wrap-safe due test: now - due, read as signed, not negative
  assign late = now_q - ram_rdata.next_due;
  assign fire = ev_vld_q && active_q[ev_idx_q] && !late[31];

  rtt_ram #(
    .WIDTH(SlotBits),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(rdata_raw)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_vld_i) begin
          state_d = cmd_i.is_tick ? ST_TICK : ST_ADD;
        end
      end
      ST_ADD: begin
        if (!active_q[idx_q] || idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o    = 1'b0;
    idx_d        = idx_q;
    now_d        = now_q;
    active_d     = active_q;
    ev_vld_d     = 1'b0;
    ev_idx_d     = ev_idx_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = '{next_due: now_q, period: cmd_q.period, remaining: cmd_q.reps};
    pend_vld_d   = pend_vld_q;
    pend_kind_d  = pend_kind_q;
    pend_idx_d   = pend_idx_q;
    pend_freed_d = pend_freed_q;
    out_stb_d    = 1'b0;
    out_kind_d   = out_kind_q;
    out_idx_d    = out_idx_q;
    out_freed_d  = out_freed_q;
    out_last_d   = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          idx_d     = '0;
          if (cmd_i.is_tick) begin
            now_d = now_q + 32'd1;
          end
        end
      end
      ST_ADD: begin
        if (!active_q[idx_q]) begin
          ram_we          = 1'b1;
          active_d[idx_q] = 1'b1;
          out_stb_d       = 1'b1;
          out_kind_d      = KIND_ADDED;
          out_idx_d       = idx4;
          out_freed_d     = 1'b0;
          out_last_d      = 1'b1;
        end else if (idx_q == LAST_IDX) begin
          out_stb_d   = 1'b1;
          out_kind_d  = KIND_FULL;
          out_idx_d   = 4'd0;
          out_freed_d = 1'b0;
          out_last_d  = 1'b1;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_TICK: begin
        ram_re   = 1'b1;
        ev_vld_d = 1'b1;
        ev_idx_d = idx_q;
        idx_d    = idx_q + IDX_W'(1);
      end
      ST_FLUSH: begin
        if (pend_vld_q) begin
          out_stb_d   = 1'b1;
          out_kind_d  = pend_kind_q;
          out_idx_d   = pend_idx_q;
          out_freed_d = pend_freed_q;
          out_last_d  = 1'b1;
        end
        pend_vld_d = 1'b0;
      end
      default: begin
      end
    endcase

    // evaluate the slot read in the previous cycle
    if (fire) begin
      if (pend_vld_q) begin
        out_stb_d   = 1'b1;
        out_kind_d  = pend_kind_q;
        out_idx_d   = pend_idx_q;
        out_freed_d = pend_freed_q;
        out_last_d  = 1'b0;
      end
      pend_vld_d = 1'b1;
      pend_idx_d = ev_idx4;
      if (ram_rdata.remaining == 32'd0) begin
        active_d[ev_idx_q] = 1'b0;
        pend_kind_d        = KIND_REMOVED;
        pend_freed_d       = 1'b1;
      end else if (ram_rdata.remaining == 32'd1) begin
        active_d[ev_idx_q] = 1'b0;
        pend_kind_d        = KIND_FIRED;
        pend_freed_d       = 1'b1;
      end else begin
        ram_we       = 1'b1;
        ram_waddr    = ev_idx_q;
        ram_wdata    = '{next_due: ram_rdata.next_due + ram_rdata.period,
                         period: ram_rdata.period,
                         remaining: ram_rdata.remaining - 32'd1};
        pend_kind_d  = KIND_FIRED;
        pend_freed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      now_q      <= 32'd0;
      active_q   <= '0;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_stb_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      now_q      <= now_d;
      active_q   <= active_d;
      ev_vld_q   <= ev_vld_d;
      pend_vld_q <= pend_vld_d;
      out_stb_q  <= out_stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    ev_idx_q     <= ev_idx_d;
    pend_kind_q  <= pend_kind_d;
    pend_idx_q   <= pend_idx_d;
    pend_freed_q <= pend_freed_d;
    out_kind_q   <= out_kind_d;
    out_idx_q    <= out_idx_d;
    out_freed_q  <= out_freed_d;
    out_last_q   <= out_last_d;
  end

  assign strobe_o     = out_stb_q;
  assign event_kind_o = out_kind_q;
  assign slot_index_o = out_idx_q;
  assign slot_freed_o = out_freed_q;
  assign last_o       = out_last_q;

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_ADD) |-> !pend_vld_q)
    else $error("held result left over outside a tick scan");

  a_eval_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_vld_q |-> (state_q == ST_TICK || state_q == ST_DRAIN))
    else $error("slot evaluated outside a tick scan");

  a_now_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.is_tick) |=> (now_q == $past(now_q) + 32'd1))
    else $error("time counter did not advance on tick");

  a_add_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_stb_q && (out_kind_q == KIND_ADDED || out_kind_q == KIND_FULL)) |-> out_last_q)
    else $error("add result not marked last");

endmodule

FILE: hw/rtl/repeating_timer_table_core.sv
// table of repeating timers driven by a millisecond tick
// command channel: an item is taken on a clock edge with start_i high and
// busy_o low; opcode_i selects add (interval_ms_i, repeat_total_i) or tick.
// a two-entry command queue sits in front of the table engine, so busy_o
// only rises when two commands are waiting behind the one in progress.
// result channel: every beat is on the result ports for exactly one cycle
// while strobe_o is high; last_o marks the final beat of a command. the
// receiver has no way to hold results off.
// add: scans the slot flags one per cycle and takes the first free slot.
// tick: the slot memory is read one slot per cycle with the evaluation of
// the previous slot overlapped; the engine takes the next command only after
// the scan, the drain and the flush. fired slots come out in ascending slot
// order, a tick with nothing due gives no beat. the scan goes through the
// single read port of the slot memory.
// reset clears the time counter, all slot flags and the queue; slot memory
// contents are not cleared and are used only for slots that were added.
module repeating_timer_table_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [31:0] interval_ms_i,
  input  logic [31:0] repeat_total_i,
  output logic        strobe_o,
  output logic [1:0]  event_kind_o,
  output logic [3:0]  slot_index_o,
  output logic        slot_freed_o,
  output logic        last_o
);
  import rtt_pkg::*;

  cmd_t cmd;
  logic cmd_vld;
  logic cmd_pop;

  rtt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .opcode_i      (opcode_i),
    .interval_ms_i (interval_ms_i),
    .repeat_total_i(repeat_total_i),
    .busy_o        (busy_o),
    .cmd_vld_o     (cmd_vld),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  rtt_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_vld_i   (cmd_vld),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .strobe_o    (strobe_o),
    .event_kind_o(event_kind_o),
    .slot_index_o(slot_index_o),
    .slot_freed_o(slot_freed_o),
    .last_o      (last_o)
  );

endmodule

FILE: verif/timer_table_checker.sv
`timescale 1ns / 1ps

module timer_table_checker #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic        opcode_i,
  input  logic [31:0] interval_ms_i,
  input  logic [31:0] repeat_total_i,
  input  logic        strobe_o,
  input  logic [1:0]  event_kind_o,
  input  logic [3:0]  slot_index_o,
  input  logic        slot_freed_o,
  input  logic        last_o,
  output int          mismatch_count_o,
  output int          pending_count_o
);
  import rtt_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] slot;
    logic       freed;
    logic       last;
  } timer_event_t;

  timer_event_t expected_events[$];

  // shadow copy of the table
  logic [31:0] now_ms_q;
  logic        active_q[SLOTS];
  logic [31:0] due_q[SLOTS];
  logic [31:0] period_q[SLOTS];
  logic [31:0] left_q[SLOTS];

  task automatic push_event(input kind_e kind, input int slot, input logic freed,
                            input logic last);
    timer_event_t ev;
    ev.kind  = kind;
    ev.slot  = 4'(slot);
    ev.freed = freed;
    ev.last  = last;
    expected_events.push_back(ev);
  endtask

  task automatic predict_timer_events(input op_e op, input logic [31:0] interval,
                                      input logic [31:0] reps);
    int          found;
    int          first;
    logic [31:0] lag;
    timer_event_t ev;
    found = -1;
    if (op == OP_ADD) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!active_q[i] && found < 0) found = i;
      end
      if (found >= 0) begin
        active_q[found] = 1'b1;
        due_q[found]    = now_ms_q;
        period_q[found] = (interval == 32'd0) ? 32'd1 : interval;
        left_q[found]   = reps;
        push_event(KIND_ADDED, found, 1'b0, 1'b1);
      end else begin
        push_event(KIND_FULL, 0, 1'b0, 1'b1);
      end
    end else begin
      now_ms_q = now_ms_q + 32'd1;
      first = expected_events.size();
      for (int i = 0; i < SLOTS; i++) begin
        lag = now_ms_q - due_q[i];
        if (active_q[i] && !lag[31]) begin
          if (left_q[i] == 32'd0) begin
            active_q[i] = 1'b0;
            push_event(KIND_REMOVED, i, 1'b1, 1'b0);
          end else begin
            left_q[i] = left_q[i] - 32'd1;
            if (left_q[i] == 32'd0) begin
              active_q[i] = 1'b0;
              push_event(KIND_FIRED, i, 1'b1, 1'b0);
            end else begin
              due_q[i] = due_q[i] + period_q[i];
              push_event(KIND_FIRED, i, 1'b0, 1'b0);
            end
          end
        end
      end
      // final beat of the tick carries last
      if (expected_events.size() > first) begin
        ev = expected_events.pop_back();
        ev.last = 1'b1;
        expected_events.push_back(ev);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_event_t want;
    timer_event_t got;
    if (!rst_ni) begin
      now_ms_q = 32'd0;
      for (int i = 0; i < SLOTS; i++) begin
        active_q[i] = 1'b0;
        due_q[i]    = 32'd0;
        period_q[i] = 32'd0;
        left_q[i]   = 32'd0;
      end
      expected_events.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      // results belong to earlier commands, so compare before predicting
      if (strobe_o) begin
        got.kind  = kind_e'(event_kind_o);
        got.slot  = slot_index_o;
        got.freed = slot_freed_o;
        got.last  = last_o;
        if (expected_events.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected beat kind=%0d slot=%0d freed=%0b last=%0b",
                   $realtime, got.kind, got.slot, got.freed, got.last);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            mismatch_count_o++;
            $display("%0t: mismatch expected kind=%0d slot=%0d freed=%0b last=%0b",
                     $realtime, want.kind, want.slot, want.freed, want.last);
            $display("%0t:          actual   kind=%0d slot=%0d freed=%0b last=%0b",
                     $realtime, got.kind, got.slot, got.freed, got.last);
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_timer_events(op_e'(opcode_i), interval_ms_i, repeat_total_i);
      end
      pending_count_o = expected_events.size();
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import rtt_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned DRAIN_CYCLES = 4 * (SLOTS + 3) + 24;
  localparam int unsigned RANDOM_CMDS  = 148;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        opcode_i;
  logic [31:0] interval_ms_i;
  logic [31:0] repeat_total_i;
  logic        strobe_o;
  logic [1:0]  event_kind_o;
  logic [3:0]  slot_index_o;
  logic        slot_freed_o;
  logic        last_o;
  int          mismatch_count;
  int          pending_count;

  int unsigned phase_idle_pct[4] = '{0, 72, 0, 26};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  repeating_timer_table_core #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .interval_ms_i (interval_ms_i),
    .repeat_total_i(repeat_total_i),
    .strobe_o      (strobe_o),
    .event_kind_o  (event_kind_o),
    .slot_index_o  (slot_index_o),
    .slot_freed_o  (slot_freed_o),
    .last_o        (last_o)
  );

  timer_table_checker #(
    .SLOTS(SLOTS)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .interval_ms_i   (interval_ms_i),
    .repeat_total_i  (repeat_total_i),
    .strobe_o        (strobe_o),
    .event_kind_o    (event_kind_o),
    .slot_index_o    (slot_index_o),
    .slot_freed_o    (slot_freed_o),
    .last_o          (last_o),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  // drive one command beat and hold it until the block takes it
  task automatic issue_cmd(input op_e op, input logic [31:0] interval,
                           input logic [31:0] reps, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i        <= 1'b0;
      opcode_i       <= 1'($urandom);
      interval_ms_i  <= $urandom;
      repeat_total_i <= $urandom;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    opcode_i       <= op;
    interval_ms_i  <= interval;
    repeat_total_i <= reps;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic issue_random_cmd(input int unsigned idle_pct);
    logic [31:0] interval;
    logic [31:0] reps;
    int unsigned pick;
    if ($urandom_range(99) < 55) begin
      issue_cmd(OP_TICK, $urandom, $urandom, idle_pct);
    end else begin
      pick = $urandom_range(99);
      if (pick < 6) interval = $urandom;
      else if (pick < 10) interval = 32'd0;
      else if (pick < 13) interval = 32'hffff_ffff - 32'($urandom_range(7));
      else interval = 32'($urandom_range(6, 1));
      // long-lived slots are kept rare so the table keeps turning over
      pick = $urandom_range(99);
      if (pick < 4) reps = $urandom;
      else if (pick < 14) reps = 32'd0;
      else reps = 32'($urandom_range(5, 1));
      issue_cmd(OP_ADD, interval, reps, idle_pct);
    end
  endtask

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    opcode_i       <= OP_ADD;
    interval_ms_i  <= 32'd0;
    repeat_total_i <= 32'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on an empty table, then the corner intervals and counts
    issue_cmd(OP_TICK, 32'd0, 32'd0, 0);
    issue_cmd(OP_ADD, 32'd0, 32'd0, 0);
    issue_cmd(OP_ADD, 32'd0, 32'd1, 0);
    issue_cmd(OP_ADD, 32'hffff_ffff, 32'd2, 0);
    issue_cmd(OP_ADD, 32'h8000_0000, 32'd2, 0);
    issue_cmd(OP_ADD, 32'h8000_0001, 32'hffff_ffff, 0);
    issue_cmd(OP_TICK, 32'hffff_ffff, 32'hffff_ffff, 0);
    issue_cmd(OP_TICK, 32'd0, 32'd0, 0);
    // fill the table and overflow it, then release most of it in one tick
    repeat (14) issue_cmd(OP_ADD, 32'd3, 32'd1, 0);
    issue_cmd(OP_ADD, 32'd7, 32'd2, 0);
    issue_cmd(OP_TICK, 32'd0, 32'd0, 0);

    for (int p = 0; p < 4; p++) begin
      repeat (RANDOM_CMDS / 4) issue_random_cmd(phase_idle_pct[p]);
    end
    start_i <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
